/* sv/grid_ray_caster_core_macros.svh */
// Assertion macros shared by the grid ray caster RTL.
`ifndef GRID_RAY_CASTER_CORE_MACROS_SVH
`define GRID_RAY_CASTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define GRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid ray caster: same-cycle check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define GRC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid ray caster: next-cycle check failed");
`else
`define GRC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GRC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/grc_pkg.sv */
// Shared constants and types of the grid ray caster.
package grc_pkg;

   // Map and screen geometry.
   localparam int MAP_DIM       = 64;
   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 768;
   localparam int MAP_CELLS     = MAP_DIM * MAP_DIM;
   localparam int MAP_AW        = $clog2(MAP_CELLS);
   localparam int CIDX_W        = $clog2(MAP_DIM);

   // Field and datapath widths.
   localparam int COL_W   = 10;
   localparam int CELL_W  = 6;
   localparam int POS_W   = 22;
   localparam int DIR_W   = 18;
   localparam int GRID_W  = 7;
   localparam int CAM_W   = 28;
   localparam int RAY_W   = 32;
   localparam int SIDE_W  = 41;
   localparam int CRD_W   = 9;
   localparam int DIST_W  = 32;
   localparam int HT_W    = 16;
   localparam int ROW_W   = 10;
   localparam int DIV_W   = 33;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam int Q_ONE   = 65536;

   // Request kinds.
   typedef enum logic {
      REQ_MAP_WRITE = 1'b0,
      REQ_CAST      = 1'b1
   } grc_req_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_POS_X   = 3'd0,
      REG_POS_Y   = 3'd1,
      REG_DIR_X   = 3'd2,
      REG_DIR_Y   = 3'd3,
      REG_PLANE_X = 3'd4,
      REG_PLANE_Y = 3'd5,
      REG_GRID_W  = 3'd6,
      REG_GRID_H  = 3'd7
   } grc_reg_type;

   // Sequencer states.
   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_RAY    = 11'b000_0000_0100,
      S_DIVX   = 11'b000_0000_1000,
      S_DIVY   = 11'b000_0001_0000,
      S_SIDE   = 11'b000_0010_0000,
      S_STEP   = 11'b000_0100_0000,
      S_LOOK   = 11'b000_1000_0000,
      S_DIST   = 11'b001_0000_0000,
      S_DIVH   = 11'b010_0000_0000,
      S_FINISH = 11'b100_0000_0000
   } grc_state_type;

endpackage

/* sv/grid_ray_caster_core.sv */
// Top level of the grid ray caster: registers, wall grid, sequencer and result stage.
//
//  Channel   Direction  Handshake            Beat
//  req_      in         req_valid/req_ready  map cell write or cast of one column
//  rsp_      out        rsp_valid/rsp_ready  one ray result per cast
//  csr_      in         APB psel/penable     one register write or read
//
// A map write goes into the grid at its accepting edge. A cast makes three passes of the shared
// divider (launch, 33 quotient bits, done) and walks the grid in S_STEP and S_LOOK, reading the
// grid memory once per step through its registered read port.
// After reset the grid is cleared one cell a cycle, all 4096 cells, with req_ready low.
// A finished result waits in the output register; map writes go on meanwhile.
`include "grid_ray_caster_core_macros.svh"
module grid_ray_caster_core import grc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [COL_W-1:0]    req_column,
   input  logic [CELL_W-1:0]   req_cell_col,
   input  logic [CELL_W-1:0]   req_cell_row,
   input  logic                req_cell_is_wall,
   // Result channel.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COL_W-1:0]    rsp_out_column,
   output logic                rsp_wall_hit,
   output logic                rsp_hit_side,
   output logic [DIST_W-1:0]   rsp_perp_dist,
   output logic [HT_W-1:0]     rsp_slice_height,
   output logic [ROW_W-1:0]    rsp_draw_top,
   output logic [ROW_W-1:0]    rsp_draw_bottom,
   output logic [HT_W-1:0]     rsp_wall_frac,
   output logic [CELL_W-1:0]   rsp_end_cell_col,
   output logic [CELL_W-1:0]   rsp_end_cell_row,
   // Configuration port.
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam logic [DIV_W-1:0]  RECIP_NUM = DIV_W'(64'd1 << 32);
   localparam logic [DIV_W-1:0]  HT_NUM    = DIV_W'(SCREEN_HEIGHT * Q_ONE);
   localparam logic [ROW_W+7:0]  H_HALF    = (ROW_W+8)'(SCREEN_HEIGHT / 2);
   localparam logic [ROW_W+7:0]  H_LAST    = (ROW_W+8)'(SCREEN_HEIGHT - 1);

   grc_state_type state_ff, state_in;

   // Configuration registers.
   logic        [POS_W-1:0]  pos_x_ff, pos_y_ff;
   logic signed [DIR_W-1:0]  dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;
   logic        [GRID_W-1:0] grid_w_ff, grid_h_ff;

   // Cast datapath.
   logic        [MAP_AW-1:0] clr_ff;
   logic        [COL_W-1:0]  col_ff;
   logic signed [CAM_W-1:0]  cam_ff;
   logic signed [RAY_W-1:0]  rdx_ff, rdy_ff;
   logic        [DIST_W-1:0] dx_ff, dy_ff;
   logic        [SIDE_W-1:0] sx_ff, sy_ff;
   logic signed [CRD_W-1:0]  mx_ff, my_ff;
   logic                     side_ff, hit_ff, launch_ff;
   logic        [DIST_W-1:0] wd_ff, prod_ff;
   logic        [HT_W-1:0]   lh_ff;

   // Result register.
   logic                     rsp_valid_ff;
   logic        [COL_W-1:0]  rsp_col_ff;
   logic                     rsp_hit_ff, rsp_side_ff;
   logic        [DIST_W-1:0] rsp_dist_ff;
   logic        [HT_W-1:0]   rsp_ht_ff, rsp_frac_ff;
   logic        [ROW_W-1:0]  rsp_top_ff, rsp_bot_ff;
   logic        [CELL_W-1:0] rsp_ecol_ff, rsp_erow_ff;

   logic                     req_fire, csr_wr, rsp_load;
   grc_reg_type              csr_idx;
   logic        [CAM_W-1:0]  cam_u;
   logic signed [DIR_W+CAM_W-1:0] mulx, muly;
   logic        [DIST_W-1:0] abs_x, abs_y;
   logic        [16:0]       fsel_x, fsel_y;
   logic        [48:0]       msx, msy;
   logic                     take_x;
   logic signed [CRD_W-1:0]  mx_n, my_n;
   logic        [MAP_AW-1:0] rd_addr, wr_addr;
   logic                     ram_we, ram_wdata, ram_rdata;
   logic                     at_edge, in_store;
   logic signed [CRD_W-1:0]  h_lim, w_lim;
   logic        [SIDE_W-1:0] wsel;
   logic        [DIST_W-1:0] rdo;
   logic        [2*DIST_W-1:0] pfull;
   logic                     div_start, div_done, div_state;
   logic        [DIV_W-1:0]  div_dividend, div_quot;
   logic        [DIV_W-2:0]  div_divisor;
   logic        [DIST_W-1:0] q_sat;
   logic        [ROW_W+7:0]  half, top_v, bot_v;
   logic        [HT_W-1:0]   frac_v;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx   = grc_reg_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_pready = 1'b1;

   // Register read-back.
   always_comb begin
      case (csr_idx)
         REG_POS_X:   csr_prdata = CSR_DW'(pos_x_ff);
         REG_POS_Y:   csr_prdata = CSR_DW'(pos_y_ff);
         REG_DIR_X:   csr_prdata = CSR_DW'(unsigned'(dir_x_ff));
         REG_DIR_Y:   csr_prdata = CSR_DW'(unsigned'(dir_y_ff));
         REG_PLANE_X: csr_prdata = CSR_DW'(unsigned'(plane_x_ff));
         REG_PLANE_Y: csr_prdata = CSR_DW'(unsigned'(plane_y_ff));
         REG_GRID_W:  csr_prdata = CSR_DW'(grid_w_ff);
         REG_GRID_H:  csr_prdata = CSR_DW'(grid_h_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         dir_x_ff   <= DIR_W'(Q_ONE);
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= DIR_W'(43254);
         grid_w_ff  <= GRID_W'(64);
         grid_h_ff  <= GRID_W'(64);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_POS_X:   pos_x_ff   <= csr_pwdata[POS_W-1:0];
            REG_POS_Y:   pos_y_ff   <= csr_pwdata[POS_W-1:0];
            REG_DIR_X:   dir_x_ff   <= csr_pwdata[DIR_W-1:0];
            REG_DIR_Y:   dir_y_ff   <= csr_pwdata[DIR_W-1:0];
            REG_PLANE_X: plane_x_ff <= csr_pwdata[DIR_W-1:0];
            REG_PLANE_Y: plane_y_ff <= csr_pwdata[DIR_W-1:0];
            REG_GRID_W:  grid_w_ff  <= csr_pwdata[GRID_W-1:0];
            REG_GRID_H:  grid_h_ff  <= csr_pwdata[GRID_W-1:0];
            default:     ;
         endcase
      end
   end

   // Camera x of the column, ray direction products and reciprocal operands.
   assign cam_u = CAM_W'({req_column, 17'b0} / SCREEN_WIDTH);
   assign mulx  = plane_x_ff * cam_ff;
   assign muly  = plane_y_ff * cam_ff;
   assign abs_x = rdx_ff[RAY_W-1] ? DIST_W'(-rdx_ff) : DIST_W'(rdx_ff);
   assign abs_y = rdy_ff[RAY_W-1] ? DIST_W'(-rdy_ff) : DIST_W'(rdy_ff);

   // Distance from the position to the first cell boundary along each axis.
   assign fsel_x = rdx_ff[RAY_W-1] ? {1'b0, pos_x_ff[15:0]} : 17'h10000 - {1'b0, pos_x_ff[15:0]};
   assign fsel_y = rdy_ff[RAY_W-1] ? {1'b0, pos_y_ff[15:0]} : 17'h10000 - {1'b0, pos_y_ff[15:0]};
   assign msx    = fsel_x * dx_ff;
   assign msy    = fsel_y * dy_ff;

   // One DDA step: the axis with the nearer boundary advances.
   assign take_x = sx_ff < sy_ff;
   assign mx_n = take_x ? mx_ff + (rdx_ff[RAY_W-1] ? {CRD_W{1'b1}} : CRD_W'(1)) : mx_ff;
   assign my_n = take_x ? my_ff : my_ff + (rdy_ff[RAY_W-1] ? {CRD_W{1'b1}} : CRD_W'(1));
   assign rd_addr = MAP_AW'(32'(my_n[CIDX_W-1:0]) * MAP_DIM + 32'(mx_n[CIDX_W-1:0]));

   // Edge limits and storage bounds of the cell just entered.
   assign h_lim    = CRD_W'(grid_h_ff);
   assign w_lim    = CRD_W'(grid_w_ff) - CRD_W'(1);
   assign at_edge  = (my_ff < 1) || (mx_ff < 1) || (my_ff >= h_lim) || (mx_ff >= w_lim);
   assign in_store = (mx_ff >= 0) && (mx_ff < MAP_DIM) && (my_ff >= 0) && (my_ff < MAP_DIM);

   // Perpendicular distance and the wall-coordinate product.
   assign wsel  = side_ff ? sy_ff - SIDE_W'(dy_ff) : sx_ff - SIDE_W'(dx_ff);
   assign rdo   = side_ff ? DIST_W'(rdx_ff) : DIST_W'(rdy_ff);
   assign pfull = wd_ff * rdo;

   // Grid memory: clearing pass after reset, then map writes.
   assign wr_addr   = (state_ff == S_CLEAR) ? clr_ff
                    : MAP_AW'(32'(req_cell_row) * MAP_DIM + 32'(req_cell_col));
   assign ram_we    = (state_ff == S_CLEAR)
                    || (req_fire && (req_type == REQ_MAP_WRITE)
                        && (32'(req_cell_col) < MAP_DIM) && (32'(req_cell_row) < MAP_DIM));
   assign ram_wdata = (state_ff == S_CLEAR) ? 1'b0 : req_cell_is_wall;

   grc_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   // Shared divider: two reciprocals, then the slice height.
   assign div_state    = (state_ff == S_DIVX) || (state_ff == S_DIVY) || (state_ff == S_DIVH);
   assign div_start    = launch_ff && div_state;
   assign div_dividend = (state_ff == S_DIVH) ? HT_NUM : RECIP_NUM;
   assign div_divisor  = (state_ff == S_DIVX) ? abs_x : (state_ff == S_DIVY) ? abs_y : wd_ff;
   assign q_sat        = div_quot[DIV_W-1] ? '1 : div_quot[DIST_W-1:0];

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot)
   );

   // Draw rows and wall coordinate of the finished cast.
   assign half   = (ROW_W+8)'(lh_ff[HT_W-1:1]);
   assign top_v  = (half >= H_HALF) ? '0 : H_HALF - half;
   assign bot_v  = (H_HALF + half > H_LAST) ? H_LAST : H_HALF + half;
   assign frac_v = (side_ff ? pos_x_ff[15:0] : pos_y_ff[15:0]) + prod_ff[31:16];
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (clr_ff == MAP_AW'(MAP_CELLS - 1)) state_in = S_IDLE;
         S_IDLE:   if (req_fire && (req_type == REQ_CAST)) state_in = S_RAY;
         S_RAY:    state_in = S_DIVX;
         S_DIVX:   if (div_done) state_in = S_DIVY;
         S_DIVY:   if (div_done) state_in = S_SIDE;
         S_SIDE:   state_in = S_STEP;
         S_STEP:   state_in = S_LOOK;
         S_LOOK:   if (at_edge || (in_store && ram_rdata)) state_in = S_DIST;
                   else state_in = S_STEP;
         S_DIST:   state_in = S_DIVH;
         S_DIVH:   if (div_done) state_in = S_FINISH;
         S_FINISH: if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= (state_ff == S_RAY) || (state_ff == S_DIST)
                   || ((state_ff == S_DIVX) && div_done);
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + MAP_AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Cast datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            col_ff <= req_column;
            cam_ff <= cam_u - CAM_W'(Q_ONE);
         end
         S_RAY: begin
            rdx_ff <= RAY_W'(dir_x_ff) + RAY_W'(mulx >>> 16);
            rdy_ff <= RAY_W'(dir_y_ff) + RAY_W'(muly >>> 16);
         end
         S_DIVX: if (div_done) dx_ff <= q_sat;
         S_DIVY: if (div_done) dy_ff <= q_sat;
         S_SIDE: begin
            sx_ff <= SIDE_W'(msx[48:16]);
            sy_ff <= SIDE_W'(msy[48:16]);
            mx_ff <= CRD_W'(pos_x_ff[POS_W-1:16]);
            my_ff <= CRD_W'(pos_y_ff[POS_W-1:16]);
         end
         S_STEP: begin
            if (take_x) sx_ff <= sx_ff + SIDE_W'(dx_ff);
            else        sy_ff <= sy_ff + SIDE_W'(dy_ff);
            mx_ff   <= mx_n;
            my_ff   <= my_n;
            side_ff <= !take_x;
         end
         S_LOOK: hit_ff <= !at_edge && in_store && ram_rdata;
         S_DIST: wd_ff <= (|wsel[SIDE_W-1:DIST_W]) ? '1 : wsel[DIST_W-1:0];
         S_DIVH: begin
            prod_ff <= pfull[DIST_W-1:0];
            if (div_done) lh_ff <= (|q_sat[DIST_W-1:HT_W]) ? '1 : q_sat[HT_W-1:0];
         end
         default: ;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff  <= col_ff;
         rsp_hit_ff  <= hit_ff;
         rsp_side_ff <= side_ff;
         rsp_dist_ff <= wd_ff;
         rsp_ht_ff   <= lh_ff;
         rsp_top_ff  <= top_v[ROW_W-1:0];
         rsp_bot_ff  <= bot_v[ROW_W-1:0];
         rsp_frac_ff <= frac_v;
         rsp_ecol_ff <= mx_ff[CELL_W-1:0];
         rsp_erow_ff <= my_ff[CELL_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_column   = rsp_col_ff;
   assign rsp_wall_hit     = rsp_hit_ff;
   assign rsp_hit_side     = rsp_side_ff;
   assign rsp_perp_dist    = rsp_dist_ff;
   assign rsp_slice_height = rsp_ht_ff;
   assign rsp_draw_top     = rsp_top_ff;
   assign rsp_draw_bottom  = rsp_bot_ff;
   assign rsp_wall_frac    = rsp_frac_ff;
   assign rsp_end_cell_col = rsp_ecol_ff;
   assign rsp_end_cell_row = rsp_erow_ff;

   // The grid is written only by the clearing pass or by an accepted map beat.
   `GRC_ASSERT_IMP(a_grid_write_source, clock, reset, ram_we, (state_ff == S_CLEAR) || req_fire)
   // The divider finishes only while the sequencer waits for it.
   `GRC_ASSERT_IMP(a_div_done_waited, clock, reset, div_done, div_state)
   // Side distances never shrink during the walk.
   `GRC_ASSERT_NXT(a_side_monotonic, clock, reset, state_ff == S_STEP, (sx_ff >= $past(sx_ff)) && (sy_ff >= $past(sy_ff)))

endmodule

/* sv/grc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/grc_div.sv */
// Restoring divider that retires one quotient bit per cycle.
module grc_div import grc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [DIV_W-2:0]   divisor,
   output logic               done,
   output logic [DIV_W-1:0]   quot
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-2:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-2:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DIV_W-1:0] trial;
   logic [DIV_W-1:0] diff;
   logic             fits;

   // Trial subtraction of the divisor from the shifted partial remainder.
   // A zero divisor fits every time and yields an all-ones quotient.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   // Control: run until every dividend bit has been retired, then pulse done.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == '0);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIV_W - 1);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath: the quotient register shifts the dividend out as bits come in.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fits ? diff[DIV_W-2:0] : trial[DIV_W-2:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule
